/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* rtl/b64d_pkg.sv */
// Package with the shared types and the character map of the base64 decoder.
`timescale 1ns / 1ps

package b64d_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef struct packed {
		logic       valid;
		logic [5:0] value;
	} sextet_t;

	typedef struct packed {
		logic       has_result;
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       end_of_message;
	} dec_res_t;

	function automatic sextet_t char_to_sextet(input logic [7:0] ch);
		sextet_t s;
		s.valid = 1'b1;
		s.value = 6'd0;
		case (ch) inside
			[8'h41:8'h5A]: s.value = 6'(ch - 8'h41);
			[8'h61:8'h7A]: s.value = 6'(ch - 8'h47);
			[8'h30:8'h39]: s.value = 6'(ch + 8'h04);
			8'h2B, 8'h2D:  s.value = 6'd62;
			8'h2F, 8'h5F:  s.value = 6'd63;
			default:       s.valid = 1'b0;
		endcase
		return s;
	endfunction

endpackage

/* rtl/b64d_decode.sv */
// Decode logic and group state: maps one character and forms the result item.
`timescale 1ns / 1ps

module b64d_decode import b64d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] char_s1,
	input  logic       last_s1,
	input  logic       advance,
	output dec_res_t   res
);

	logic [1:0] phase_q;
	logic [5:0] prior_q;
	logic       pad_q;
	sextet_t    sx;
	logic       is_pad;
	logic       take;
	logic       have_byte;
	logic [7:0] byte_val;

	always_comb begin
		sx        = char_to_sextet(char_s1);
		is_pad    = (char_s1 == PAD_CHAR);
		take      = !pad_q && !is_pad && sx.valid;
		have_byte = take && (phase_q != 2'd0);
		case (phase_q)
			2'd1:    byte_val = {prior_q, sx.value[5:4]};
			2'd2:    byte_val = {prior_q[3:0], sx.value[5:2]};
			2'd3:    byte_val = {prior_q[1:0], sx.value};
			default: byte_val = 8'd0;
		endcase
		res.has_result     = have_byte || last_s1;
		res.out_byte       = have_byte ? byte_val : 8'd0;
		res.byte_valid     = have_byte;
		res.end_of_message = last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			prior_q <= 6'd0;
			pad_q   <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				phase_q <= 2'd0;
				prior_q <= 6'd0;
				pad_q   <= 1'b0;
			end else begin
				if (!pad_q && is_pad) begin
					pad_q <= 1'b1;
				end
				if (take) begin
					prior_q <= sx.value;
					phase_q <= phase_q + 2'd1;
				end
			end
		end
	end

endmodule

/* rtl/b64d_out_reg.sv */
// Result register that holds one decoded item until the receiver takes it.
`timescale 1ns / 1ps

module b64d_out_reg import b64d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  dec_res_t   res,
	input  logic       out_stall,
	output logic       out_free,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       end_of_message
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic       bvalid_q;
	logic       eom_q;

	assign out_free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= res.out_byte;
			bvalid_q <= res.byte_valid;
			eom_q    <= res.end_of_message;
		end
	end

	assign out_valid      = valid_q;
	assign out_byte       = byte_q;
	assign byte_valid     = bvalid_q;
	assign end_of_message = eom_q;

endmodule

/* rtl/base64_stream_decoder_core.sv */
// Top level of the streaming base64 decoder.
// The input channel (in_valid, in_stall) moves one text character per transfer,
// with last_char set on the final character of a message. Both the standard and
// the URL-safe alphabets are decoded; other characters are skipped, and an '='
// stops decoding until the end of the message.
// The output channel (out_valid, out_stall) moves one result per transfer: a
// decoded byte with byte_valid set, and end_of_message set on the result that
// the last character always gives. Other characters give no result.
// A character enters an input register; the decode logic loads its result into
// the output register, which drives out_valid, once that register is free.
// One character is taken every cycle while in_stall is low.
// While the receiver stalls, the output register holds its result and one more
// character may wait in the input register; after that in_stall rises.
// Reset empties both registers and clears the group phase, the saved sextet
// and the padding flag; the same state is cleared after each last character.
`timescale 1ns / 1ps

module base64_stream_decoder_core import b64d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_char,
	input  logic       last_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       end_of_message
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       advance;
	logic       out_free;
	dec_res_t   res;

	assign advance  = valid_s1 && (!res.has_result || out_free);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= in_char;
			last_s1 <= last_char;
		end
	end

	b64d_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_s1 (char_s1),
		.last_s1 (last_s1),
		.advance (advance),
		.res     (res)
	);

	b64d_out_reg u_out_reg (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (advance && res.has_result),
		.res            (res),
		.out_stall      (out_stall),
		.out_free       (out_free),
		.out_valid      (out_valid),
		.out_byte       (out_byte),
		.byte_valid     (byte_valid),
		.end_of_message (end_of_message)
	);

endmodule

/* rtl/b64d_checker.sv */
// Port-level checks for the base64 decoder, bound to its top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64d_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic       end_of_message
);

	`ASSERT_SAME(a_result_has_content, clk, arst_n, out_valid, byte_valid || end_of_message)
	`ASSERT_SAME(a_empty_byte_is_zero, clk, arst_n, out_valid && !byte_valid, out_byte == 8'd0)
	`ASSERT_NEXT(a_stalled_result_holds, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(byte_valid) && $stable(end_of_message))

endmodule

bind base64_stream_decoder_core b64d_checker u_b64d_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.out_byte       (out_byte),
	.byte_valid     (byte_valid),
	.end_of_message (end_of_message)
);
